FILE: rtl/assert_macros.svh
// Assertion macros shared by the text console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag any clock edge at which cond holds.
`define TCW_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Flag any clock edge at which ante holds and cons does not.
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int RD_ROW_W   = 5;
    localparam int RD_COL_W   = 7;
    localparam int CUR_ROW_W  = 5;
    localparam int CUR_COL_W  = 7;
    localparam int CELL_W     = CHAR_W + ATTR_W;

    // Default geometry and queue depth
    localparam int ROWS_DEF    = 25;
    localparam int COLS_DEF    = 80;
    localparam int QUEUE_DEPTH = 4;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Operation codes passed from front to back
    localparam int OP_W = 3;
    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NONE        = 3'd0;
    localparam op_t OP_WRITE       = 3'd1;
    localparam op_t OP_BLANK       = 3'd2;
    localparam op_t OP_BLANK_WRITE = 3'd3;
    localparam op_t OP_CLEAR       = 3'd4;
    localparam op_t OP_READ        = 3'd5;

endpackage

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_front.sv
// Front end: keeps the cursor and scroll offset, turns commands into operations.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLS    = COLS_DEF,
    localparam int ROW_IW = $clog2(ROWS),
    localparam int CIDX_W = $clog2(COLS),
    localparam int CCOL_W = $clog2(COLS + 1),
    localparam int ADDR_W = $clog2(ROWS * COLS),
    localparam int ENTRY_W = OP_W + 2 * ADDR_W + CHAR_W + ROW_IW + CCOL_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [CMD_W-1:0]    command,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [RD_ROW_W-1:0] read_row,
    input  logic [RD_COL_W-1:0] read_col,
    output logic [ENTRY_W-1:0]  entry
);

    logic [ROW_IW-1:0] cur_row_reg, cur_row_next;
    logic [CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_IW-1:0] top_reg, top_next;

    logic              is_nl;
    logic              wrap;
    logic              scroll;
    logic [ROW_IW-1:0] top_inc;
    logic [ROW_IW-1:0] lrow;
    logic [CIDX_W-1:0] lcol;
    logic [ROW_IW:0]   psum;
    logic [ROW_IW-1:0] prow;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    op_t               op;

    always_comb
    begin
        is_nl   = (char_code == NEWLINE_CODE);
        wrap    = is_nl || (cur_col_reg == CCOL_W'(COLS));
        scroll  = wrap && (cur_row_reg == ROW_IW'(ROWS - 1));
        top_inc = (top_reg == ROW_IW'(ROWS - 1)) ? '0 : top_reg + 1'b1;

        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        top_next     = top_reg;
        op           = OP_NONE;
        lrow         = ROW_IW'(read_row);
        lcol         = CIDX_W'(read_col);

        case (command)
            CMD_PUT:
            begin
                if (wrap)
                begin
                    if (scroll)
                    begin
                        top_next = top_inc;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                lrow = cur_row_next;
                if (is_nl)
                begin
                    cur_col_next = '0;
                    lcol         = '0;
                    op           = scroll ? OP_BLANK : OP_NONE;
                end
                else
                begin
                    if (wrap)
                    begin
                        lcol         = '0;
                        cur_col_next = CCOL_W'(1);
                    end
                    else
                    begin
                        lcol         = CIDX_W'(cur_col_reg);
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                    op = scroll ? OP_BLANK_WRITE : OP_WRITE;
                end
            end
            CMD_CLEAR:
            begin
                op = OP_CLEAR;
            end
            CMD_READ:
            begin
                if ((int'(read_row) < ROWS) && (int'(read_col) < COLS))
                begin
                    op = OP_READ;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase

        // Logical row to physical row through the scroll offset
        psum = {1'b0, top_next} + {1'b0, lrow};
        if (psum >= (ROW_IW + 1)'(ROWS))
        begin
            prow = ROW_IW'(psum - (ROW_IW + 1)'(ROWS));
        end
        else
        begin
            prow = psum[ROW_IW-1:0];
        end
        base = ADDR_W'(prow) * ADDR_W'(COLS);
        addr = base + ADDR_W'(lcol);
    end

    assign entry = {op, base, addr, char_code, cur_row_next, cur_col_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
        end
        else if (accept)
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            top_reg     <= top_next;
        end
    end

endmodule

FILE: rtl/tcw_queue.sv
// Short operation queue between front and back.
`include "assert_macros.svh"

module tcw_queue
    import tcw_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `TCW_ASSERT_NEVER(a_push_when_full, push && full, "item pushed into a full queue")
    `TCW_ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(DEPTH), "queue count beyond depth")

endmodule

FILE: rtl/tcw_back.sv
// Back end: runs queued operations on the cell store and returns results.
`include "assert_macros.svh"

module tcw_back
    import tcw_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLS    = COLS_DEF,
    localparam int ROW_IW = $clog2(ROWS),
    localparam int CCOL_W = $clog2(COLS + 1),
    localparam int ADDR_W = $clog2(ROWS * COLS),
    localparam int ENTRY_W = OP_W + 2 * ADDR_W + CHAR_W + ROW_IW + CCOL_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [ENTRY_W-1:0]   q_head,
    output logic                 q_pop,
    input  logic [ATTR_W-1:0]    text_attribute,
    output logic                 init_busy,
    output logic                 done,
    output logic [CHAR_W-1:0]    cell_char,
    output logic [ATTR_W-1:0]    cell_attr,
    output logic [CUR_ROW_W-1:0] cursor_row,
    output logic [CUR_COL_W-1:0] cursor_col
);

    localparam int CCOL_LSB = 0;
    localparam int CROW_LSB = CCOL_LSB + CCOL_W;
    localparam int CH_LSB   = CROW_LSB + ROW_IW;
    localparam int ADDR_LSB = CH_LSB + CHAR_W;
    localparam int BASE_LSB = ADDR_LSB + ADDR_W;
    localparam int OP_LSB   = BASE_LSB + ADDR_W;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(ROWS * COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COL  = ADDR_W'(COLS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_BLANK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    op_t               head_op;
    logic [ADDR_W-1:0] head_base;
    logic [ADDR_W-1:0] head_addr;
    logic [CHAR_W-1:0] head_ch;
    logic [ROW_IW-1:0] head_crow;
    logic [CCOL_W-1:0] head_ccol;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [ROW_IW-1:0] crow_reg, crow_next;
    logic [CCOL_W-1:0] ccol_reg, ccol_next;

    logic                 done_reg, done_next;
    logic [CHAR_W-1:0]    ochar_reg, ochar_next;
    logic [ATTR_W-1:0]    oattr_reg, oattr_next;
    logic [CUR_ROW_W-1:0] orow_reg, orow_next;
    logic [CUR_COL_W-1:0] ocol_reg, ocol_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] rdata;
    logic [CELL_W-1:0] blank_cell;

    assign head_op   = q_head[OP_LSB +: OP_W];
    assign head_base = q_head[BASE_LSB +: ADDR_W];
    assign head_addr = q_head[ADDR_LSB +: ADDR_W];
    assign head_ch   = q_head[CH_LSB +: CHAR_W];
    assign head_crow = q_head[CROW_LSB +: ROW_IW];
    assign head_ccol = q_head[CCOL_LSB +: CCOL_W];

    assign blank_cell = {text_attribute, BLANK_CODE};

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ROWS * COLS)
    ) u_cells (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        base_next  = base_reg;
        addr_next  = addr_reg;
        ch_next    = ch_reg;
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        done_next  = 1'b0;
        ochar_next = ochar_reg;
        oattr_next = oattr_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = cnt_reg;
        wdata      = blank_cell;
        raddr      = head_addr;

        case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                wdata = {ATTR_RESET, BLANK_CODE};
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = head_op;
                    base_next = head_base;
                    addr_next = head_addr;
                    ch_next   = head_ch;
                    crow_next = head_crow;
                    ccol_next = head_ccol;
                    orow_next = CUR_ROW_W'(head_crow);
                    ocol_next = CUR_COL_W'(head_ccol);
                    ochar_next = '0;
                    oattr_next = '0;
                    case (head_op)
                        OP_WRITE:
                        begin
                            we        = 1'b1;
                            waddr     = head_addr;
                            wdata     = {text_attribute, head_ch};
                            done_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        OP_BLANK, OP_BLANK_WRITE:
                        begin
                            cnt_next   = '0;
                            state_next = S_BLANK;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_BLANK:
            begin
                we    = 1'b1;
                waddr = base_reg + cnt_reg;
                if (cnt_reg == LAST_COL)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_BLANK_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                we         = 1'b1;
                waddr      = addr_reg;
                wdata      = {text_attribute, ch_reg};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_READ:
            begin
                ochar_next = rdata[CHAR_W-1:0];
                oattr_next = rdata[CELL_W-1:CHAR_W];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        base_reg  <= base_next;
        addr_reg  <= addr_next;
        ch_reg    <= ch_next;
        crow_reg  <= crow_next;
        ccol_reg  <= ccol_next;
        ochar_reg <= ochar_next;
        oattr_reg <= oattr_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
    end

    assign init_busy  = (state_reg == S_INIT);
    assign done       = done_reg;
    assign cell_char  = ochar_reg;
    assign cell_attr  = oattr_reg;
    assign cursor_row = orow_reg;
    assign cursor_col = ocol_reg;

    `TCW_ASSERT_IMPLY(a_pop_needs_item, q_pop, !q_empty, "pop from an empty queue")
    `TCW_ASSERT_IMPLY(a_no_result_in_init, state_reg == S_INIT, !done_reg, "result during clearing pass")

endmodule

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: front end, operation queue, back end.
// A put or a read gives its result strobe once the back end has run it; a scrolling put
// first blanks the new bottom row, and a clear blanks every cell. Throughput: one item per
// cycle into the queue unless busy; the back end's single RAM write port sets the sustained
// rate, one cell per cycle, busy rises while the queue holds QUEUE_DEPTH items.
// Reset: asynchronous, active low; cursor to the top left, attribute to 15, then a clearing pass
// over ROWS*COLS cells (2000 by default) fills the store with blanks while busy stays high.
// Results cannot be stalled: each is shown for exactly one cycle with done high.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic [RD_ROW_W-1:0]  read_row,
    input  logic [RD_COL_W-1:0]  read_col,
    // Result channel
    output logic                 done,
    output logic [CHAR_W-1:0]    cell_char,
    output logic [ATTR_W-1:0]    cell_attr,
    output logic [CUR_ROW_W-1:0] cursor_row,
    output logic [CUR_COL_W-1:0] cursor_col,
    // Attribute register write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ATTR_W-1:0]    cfg_data
);

    localparam int ROW_IW  = $clog2(ROWS);
    localparam int CCOL_W  = $clog2(COLS + 1);
    localparam int ADDR_W  = $clog2(ROWS * COLS);
    localparam int ENTRY_W = OP_W + 2 * ADDR_W + CHAR_W + ROW_IW + CCOL_W;

    logic               accept;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] q_head;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               init_busy;
    logic [ATTR_W-1:0]  attr_reg;

    // Take a command only when the queue has room and the clearing pass is over.
    assign busy   = q_full || init_busy;
    assign accept = start && !busy;

    // The attribute register takes a write on any cycle; the user must write only while idle
    // (not enforced here), so the back end may read it live while it stores or blanks cells.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= cfg_data;
        end
    end

    // Front end: advance the cursor and the scroll offset at acceptance, and map the
    // command to one memory operation with physical addresses already worked out.
    // Scrolling rotates the row offset, so only the new bottom row is blanked.
    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .entry     (entry)
    );

    // Hold operations in order so the front end keeps taking commands while
    // the back end blanks a row or clears the screen.
    tcw_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: run each operation on the cell store and drop one result per item.
    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .text_attribute (attr_reg),
        .init_busy      (init_busy),
        .done           (done),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col)
    );

endmodule

FILE: tb/sv/text_console_writer_test.sv
// Self-checking testbench for the text console writer: directed table, then random text traffic.
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    localparam int ROWS = ROWS_DEF;
    localparam int COLS = COLS_DEF;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 150;
    // Cap on clears: each one costs a full pass over the store.
    localparam int MAX_CLEARS = 30;
    localparam int MAX_GAP = 10;

    // The one command code the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0]    chr;
        logic [ATTR_W-1:0]    attr;
        logic [CUR_ROW_W-1:0] row;
        logic [CUR_COL_W-1:0] col;
    } console_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CHAR_W-1:0]   ch;
        logic [RD_ROW_W-1:0] rr;
        logic [RD_COL_W-1:0] rc;
        logic [7:0]          reps;
        logic                typed;
        console_result_t     want;
    } stim_row_t;

    localparam console_result_t NOT_TYPED = '0;

    // Directed table. Rows with typed set carry their result written out; the rest
    // go through the predictor. A row with reps above one is sent that many times.
    localparam int DIRECTED_LEN = 20;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // blank store after reset, corners of the screen
        '{CMD_READ,   8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{BLANK_CODE, ATTR_RESET, 5'd0, 7'd0}},
        '{CMD_READ,   8'hFF, 5'd24, 7'd79,  8'd1,  1'b1, '{BLANK_CODE, ATTR_RESET, 5'd0, 7'd0}},
        // reads off the screen give zero cell fields
        '{CMD_READ,   8'h00, 5'd31, 7'd127, 8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd0}},
        '{CMD_READ,   8'h00, 5'd25, 7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd0}},
        '{CMD_READ,   8'h00, 5'd0,  7'd80,  8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd0}},
        // unused code: nothing moves
        '{CMD_UNUSED, 8'hFF, 5'd31, 7'd127, 8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd0}},
        // extreme character bytes
        '{CMD_PUT,    8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd1}},
        '{CMD_PUT,    8'hFF, 5'd31, 7'd127, 8'd1,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd2}},
        '{CMD_READ,   8'h00, 5'd0,  7'd1,   8'd1,  1'b1, '{8'hFF, ATTR_RESET, 5'd0, 7'd2}},
        // walk down to the second-last row, then onto the last and scroll once
        '{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 8'd23, 1'b0, NOT_TYPED},
        '{CMD_PUT,    8'h5A, 5'd0,  7'd0,   8'd1,  1'b0, NOT_TYPED},
        '{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 8'd1,  1'b0, NOT_TYPED},
        '{CMD_PUT,    8'h51, 5'd0,  7'd0,   8'd1,  1'b0, NOT_TYPED},
        '{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 8'd1,  1'b0, NOT_TYPED},
        '{CMD_READ,   8'h00, 5'd22, 7'd0,   8'd1,  1'b0, NOT_TYPED},
        '{CMD_READ,   8'h00, 5'd23, 7'd0,   8'd1,  1'b0, NOT_TYPED},
        '{CMD_READ,   8'h00, 5'd24, 7'd0,   8'd1,  1'b0, NOT_TYPED},
        // clear keeps the cursor where it is
        '{CMD_CLEAR,  8'h00, 5'd0,  7'd0,   8'd1,  1'b1, '{8'd0, 8'd0, 5'd24, 7'd0}},
        '{CMD_READ,   8'h00, 5'd23, 7'd0,   8'd1,  1'b1, '{BLANK_CODE, ATTR_RESET, 5'd24, 7'd0}},
        '{CMD_READ,   8'h00, 5'd24, 7'd79,  8'd1,  1'b1, '{BLANK_CODE, ATTR_RESET, 5'd24, 7'd0}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     command = CMD_PUT;
    logic [CHAR_W-1:0]    char_code = '0;
    logic [RD_ROW_W-1:0]  read_row = '0;
    logic [RD_COL_W-1:0]  read_col = '0;
    logic                 done;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ATTR_W-1:0]    cfg_data = '0;

    text_console_writer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the screen, cursor and attribute, advanced at each accepted item.
    logic [CELL_W-1:0] shadow_screen [ROWS][COLS];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [ATTR_W-1:0] shadow_attr;

    // Results still owed by the block, oldest first.
    console_result_t pending_results [$];

    bit sender_idles = 1'b1;
    int items_sent = 0;
    int cmd_count [4] = '{0, 0, 0, 0};
    int scrolls = 0;
    int wraps = 0;
    int attr_writes = 0;
    int results_seen = 0;
    int mismatches = 0;

    // Move to column 0 of the next row; on the last row shift everything up and
    // blank the bottom row with the current attribute.
    function automatic void advance_line();
        int r;
        int c;
        shadow_col = 0;
        if (shadow_row < ROWS - 1)
        begin
            shadow_row++;
        end
        else
        begin
            for (r = 1; r < ROWS; r++)
                for (c = 0; c < COLS; c++)
                    shadow_screen[r - 1][c] = shadow_screen[r][c];
            for (c = 0; c < COLS; c++)
                shadow_screen[ROWS - 1][c] = {shadow_attr, BLANK_CODE};
            scrolls++;
        end
    endfunction

    // Apply one command to the shadow state and return the result it should give.
    function automatic console_result_t apply_command(
        input logic [CMD_W-1:0]    cmd,
        input logic [CHAR_W-1:0]   ch,
        input logic [RD_ROW_W-1:0] rr,
        input logic [RD_COL_W-1:0] rc
    );
        console_result_t res;
        int r;
        int c;
        res = '0;
        case (cmd)
            CMD_PUT:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    advance_line();
                end
                else
                begin
                    // a full line wraps before the byte is stored
                    if (shadow_col >= COLS)
                    begin
                        advance_line();
                        wraps++;
                    end
                    shadow_screen[shadow_row][shadow_col] = {shadow_attr, ch};
                    shadow_col++;
                end
            end
            CMD_CLEAR:
            begin
                for (r = 0; r < ROWS; r++)
                    for (c = 0; c < COLS; c++)
                        shadow_screen[r][c] = {shadow_attr, BLANK_CODE};
            end
            CMD_READ:
            begin
                if (rr < ROWS && rc < COLS)
                    {res.attr, res.chr} = shadow_screen[rr][rc];
            end
            default:
            begin
            end
        endcase
        res.row = shadow_row[CUR_ROW_W-1:0];
        res.col = shadow_col[CUR_COL_W-1:0];
        return res;
    endfunction

    // Present one item, hold it until accepted, then log the result it owes.
    // Start is left high on return so that back-to-back items need no second assignment.
    task automatic send_item(
        input logic [CMD_W-1:0]    cmd,
        input logic [CHAR_W-1:0]   ch,
        input logic [RD_ROW_W-1:0] rr,
        input logic [RD_COL_W-1:0] rc,
        input logic                typed,
        input console_result_t     want
    );
        int gap;
        console_result_t predicted;
        gap = 0;
        while (sender_idles && gap < MAX_GAP && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
        start     <= 1'b1;
        command   <= cmd;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_command(cmd, ch, rr, rc);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        cmd_count[cmd]++;
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write the attribute register; only called with the block idle.
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    // Read a cell, half the time near the cursor where recent writes and scrolls land.
    task automatic send_read();
        int pick;
        logic [RD_ROW_W-1:0] rr;
        logic [RD_COL_W-1:0] rc;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            rr = (shadow_row > 0 && pick[0]) ? RD_ROW_W'(shadow_row - 1) : RD_ROW_W'(shadow_row);
            rc = RD_COL_W'($urandom_range(COLS - 1));
        end
        else if (pick < 9)
        begin
            rr = RD_ROW_W'($urandom_range(ROWS - 1));
            rc = RD_COL_W'($urandom_range(COLS - 1));
        end
        else
        begin
            // anywhere the fields reach, off-screen included
            rr = RD_ROW_W'($urandom_range(31));
            rc = RD_COL_W'($urandom_range(127));
        end
        send_item(CMD_READ, CHAR_W'($urandom_range(255)), rr, rc, 1'b0, NOT_TYPED);
    endtask

    // One line of text: mostly printable bytes with a few reads mixed in. Long lines
    // run past the last column and wrap; most lines end in a newline.
    task automatic send_text_line();
        int len;
        logic [CHAR_W-1:0] ch;
        len = ($urandom_range(3) == 0) ? $urandom_range(90, 70) : $urandom_range(20, 1);
        repeat (len)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_read();
            end
            else
            begin
                ch = ($urandom_range(4) == 0) ? CHAR_W'($urandom_range(255))
                                              : CHAR_W'($urandom_range(126, 32));
                send_item(CMD_PUT, ch, RD_ROW_W'($urandom_range(31)),
                          RD_COL_W'($urandom_range(127)), 1'b0, NOT_TYPED);
            end
        end
        if ($urandom_range(3) != 0)
            send_item(CMD_PUT, NEWLINE_CODE, RD_ROW_W'($urandom_range(31)),
                      RD_COL_W'($urandom_range(127)), 1'b0, NOT_TYPED);
    endtask

    // Fully random items, the unused code included.
    task automatic send_noise();
        logic [CMD_W-1:0] cmd;
        repeat ($urandom_range(4, 1))
        begin
            cmd = CMD_W'($urandom_range(3));
            if (cmd == CMD_CLEAR && cmd_count[CMD_CLEAR] >= MAX_CLEARS)
                cmd = CMD_UNUSED;
            send_item(cmd, CHAR_W'($urandom_range(255)), RD_ROW_W'($urandom_range(31)),
                      RD_COL_W'($urandom_range(127)), 1'b0, NOT_TYPED);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Results cannot be held off: take each one at the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none owed, got char %0d attr %0d row %0d col %0d",
                         $time, cell_char, cell_attr, cursor_row, cursor_col);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("cell_char", want.chr, cell_char);
                check_field("cell_attr", want.attr, cell_attr);
                check_field("cursor_row", 8'(want.row), 8'(cursor_row));
                check_field("cursor_col", 8'(want.col), 8'(cursor_col));
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;
        int phase;
        int target;
        int pick;
        bit paused_mid;
        logic [ATTR_W-1:0] phase_attr;

        paused_mid = 1'b0;
        for (i = 0; i < ROWS * COLS; i++)
            shadow_screen[i / COLS][i % COLS] = {ATTR_RESET, BLANK_CODE};
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = ATTR_RESET;

        // Hold reset low, then release it; the block then runs its clearing pass with busy high.
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, at the reset attribute.
        for (i = 0; i < DIRECTED_LEN; i++)
            repeat (DIRECTED_ROWS[i].reps)
                send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].rr,
                          DIRECTED_ROWS[i].rc, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // Random phases, each at its own attribute: both extremes first, then random ones.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: phase_attr = 8'h00;
                1: phase_attr = 8'hFF;
                default: phase_attr = ATTR_W'($urandom_range(255));
            endcase
            wait_for_results();
            write_attribute(phase_attr);

            // One whole phase goes without sender gaps.
            sender_idles = (phase != 2);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    send_text_line();
                end
                else if (pick < 70)
                begin
                    repeat ($urandom_range(6, 1))
                        send_read();
                end
                else if (pick < 80)
                begin
                    // newline runs push the cursor to the bottom and keep it scrolling
                    repeat ($urandom_range(30, 1))
                        send_item(CMD_PUT, NEWLINE_CODE, RD_ROW_W'($urandom_range(31)),
                                  RD_COL_W'($urandom_range(127)), 1'b0, NOT_TYPED);
                end
                else if (pick < 86 && cmd_count[CMD_CLEAR] < MAX_CLEARS)
                begin
                    send_item(CMD_CLEAR, CHAR_W'($urandom_range(255)),
                              RD_ROW_W'($urandom_range(31)), RD_COL_W'($urandom_range(127)),
                              1'b0, NOT_TYPED);
                end
                else
                begin
                    send_noise();
                end

                // Once, halfway through a phase, let the block drain completely.
                if (phase == 3 && !paused_mid && items_sent > target - ITEMS_PER_PHASE / 2)
                begin
                    wait_for_results();
                    paused_mid = 1'b1;
                end
            end
        end

        // Drain, then watch a while longer for stray results.
        wait_for_results();
        repeat (COLS + 8)
            @(posedge clk);

        $display("Covered %0d items: %0d puts, %0d clears, %0d reads, %0d unused codes;",
                 items_sent, cmd_count[CMD_PUT], cmd_count[CMD_CLEAR], cmd_count[CMD_READ],
                 cmd_count[CMD_UNUSED]);
        $display("%0d scrolls, %0d wraps, %0d attribute writes, %0d results checked, %0d errors.",
                 scrolls, wraps, attr_writes, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #8_000_000;
        $display("%0t: timed out with %0d results owed", $time, pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/sv/text_console_writer_test.sv
